[design/job_fetch_broker_selector_core_macros.svh]
// Assertion macros for the job fetch broker selector.
`ifndef JOB_FETCH_BROKER_SELECTOR_CORE_MACROS_SVH
`define JOB_FETCH_BROKER_SELECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every clock edge outside reset.
`define JFBS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Checks that a condition implies another in the same cycle.
`define JFBS_ASSERT_IMPL(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

`else

`define JFBS_ASSERT(lbl, clk, rst, prop)
`define JFBS_ASSERT_IMPL(lbl, clk, rst, cond, expr)

`endif

`endif

[design/jfbs_pkg.sv]
// Package with the types, codes and sizes of the job fetch broker selector.
`timescale 1ns / 1ps
`default_nettype none

package jfbs_pkg;

   // Table size and derived widths.
   localparam int NUM_BROKERS = 16;
   localparam int ADDR_W      = (NUM_BROKERS > 1) ? $clog2(NUM_BROKERS) : 1;
   localparam int CNT_W       = $clog2(NUM_BROKERS + 1) + 1;
   localparam int BIDX_W      = 4;
   localparam int PRIO_W      = 32;
   localparam int QUEUE_W     = 31;
   localparam int KEY_W       = PRIO_W + QUEUE_W;
   localparam int TICK_W      = 16;
   localparam logic [TICK_W-1:0] RETRY_RESET = 16'd30000;

   // Input event codes.
   typedef enum logic [2:0] {
      OP_ANNOUNCE  = 3'd0,
      OP_REPLY_JOB = 3'd1,
      OP_REPLY_NO  = 3'd2,
      OP_REQUEST   = 3'd3,
      OP_DONE      = 3'd4,
      OP_TICK      = 3'd5
   } op_type;

   // Result action codes.
   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_GET_JOB = 3'd1,
      ACT_DELIVER = 3'd2,
      ACT_RESULT  = 3'd3,
      ACT_IGNORED = 3'd4
   } action_type;

   // Fetcher state as reported on the result channel.
   typedef enum logic [1:0] {
      FETCH_IDLE = 2'd0,
      FETCH_WAIT = 2'd1,
      FETCH_TRY  = 2'd2,
      FETCH_PROC = 2'd3
   } fetch_type;

   // Sequencer state of the top level.
   typedef enum logic [1:0] {
      CTL_READY,
      CTL_SCAN
   } ctl_type;

   // Table write request.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [PRIO_W-1:0] prio;
      logic [QUEUE_W-1:0] queue;
   } tbl_wr_type;

   // Table valid-bit clear request.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } tbl_clr_type;

   // Registered table read data.
   typedef struct packed {
      logic               valid;
      logic [PRIO_W-1:0]  prio;
      logic [QUEUE_W-1:0] queue;
   } tbl_rd_type;

   // Scan status toward the top level.
   typedef struct packed {
      logic              done;
      logic              found;
      logic [ADDR_W-1:0] best;
   } scan_stat_type;

endpackage

`default_nettype wire

[design/jfbs_table.sv]
// Broker table: priority and queue memory with one read port, plus valid bits.
`timescale 1ns / 1ps
`default_nettype none

module jfbs_table
   import jfbs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tbl_wr_type        wr,
   input  wire tbl_clr_type       clr,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output tbl_rd_type             rd_data
);

   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [QUEUE_W-1:0] queue;
   } entry_type;

   entry_type  mem [NUM_BROKERS];
   logic [NUM_BROKERS-1:0] valid_ff;
   logic [NUM_BROKERS-1:0] valid_in;
   tbl_rd_type rd_ff;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= '{prio: wr.prio, queue: wr.queue};
      end
      if (rd_en) begin
         rd_ff.prio  <= mem[rd_addr].prio;
         rd_ff.queue <= mem[rd_addr].queue;
         rd_ff.valid <= valid_ff[rd_addr];
      end
   end

   // Valid bits are set by a write and cleared by a clear request.
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
      if (clr.en) begin
         valid_in[clr.addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

[design/jfbs_scan.sv]
// Best-broker scan: reads one table entry per cycle and keeps the best so far.
`timescale 1ns / 1ps
`default_nettype none

module jfbs_scan
   import jfbs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire tbl_rd_type        rd_data,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   output scan_stat_type          stat
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BROKERS - 1);

   logic              issue_ff, issue_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              cmp_ff, cmp_in;
   logic              cmp_last_ff, cmp_last_in;
   logic [ADDR_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] best_ff, best_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              done_ff, done_in;
   logic [KEY_W-1:0]  cand;

   // Priority is made unsigned by flipping its sign bit; queue length breaks ties.
   assign cand = {~rd_data.prio[PRIO_W-1], rd_data.prio[PRIO_W-2:0], rd_data.queue};

   always_comb begin
      issue_in    = issue_ff;
      addr_in     = addr_ff;
      cmp_in      = 1'b0;
      cmp_last_in = 1'b0;
      cmp_idx_in  = addr_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      key_in      = key_ff;
      done_in     = done_ff;

      // Read issue: one address per cycle.
      if (issue_ff) begin
         cmp_in      = 1'b1;
         cmp_last_in = (addr_ff == LAST_ADDR);
         if (addr_ff == LAST_ADDR) begin
            issue_in = 1'b0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end

      // Compare the entry read in the previous cycle; a strict compare keeps
      // the lowest index among equals.
      if (cmp_ff) begin
         if (rd_data.valid && (!found_ff || (cand > key_ff))) begin
            found_in = 1'b1;
            best_in  = cmp_idx_ff;
            key_in   = cand;
         end
         if (cmp_last_ff) begin
            done_in = 1'b1;
         end
      end

      // A new scan clears the running result.
      if (start) begin
         issue_in = 1'b1;
         addr_in  = '0;
         found_in = 1'b0;
         done_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff    <= 1'b0;
         cmp_ff      <= 1'b0;
         cmp_last_ff <= 1'b0;
         found_ff    <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         issue_ff    <= issue_in;
         cmp_ff      <= cmp_in;
         cmp_last_ff <= cmp_last_in;
         found_ff    <= found_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      cmp_idx_ff <= cmp_idx_in;
      best_ff    <= best_in;
      key_ff     <= key_in;
   end

   assign rd_en      = issue_ff;
   assign rd_addr    = addr_ff;
   assign stat.done  = done_ff;
   assign stat.found = found_ff;
   assign stat.best  = best_ff;

endmodule

`default_nettype wire

[design/job_fetch_broker_selector_core.sv]
// Top level of the job fetch broker selector: event sequencer and result register.
//
// Usage: events enter on the req_ channel (op, broker_index, top_priority,
// queue_len) and are accepted when req_valid is high and req_stall is low.
// Every event yields exactly one result on the rsp_ channel (action,
// target_broker, fetch_state), held in an output register until a transfer
// with rsp_stall low. The retry timeout is written on the csr_ channel, which
// is always ready; write it only while no event is in flight.
// An event that needs no broker selection gives its result in the cycle after
// acceptance and the next event may follow in that cycle. An event that
// selects a broker scans the table one entry per cycle through the memory's
// single read port; the address, table read and done registers lie between
// acceptance and the result register, and req_stall stays high meanwhile.
// When the receiver stalls, the result register holds its value and a new
// event is taken only once the register is free or drains in that cycle.
// Reset clears all valid bits at once, sets the state to idle and loads the
// timeout with 30000; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "job_fetch_broker_selector_core_macros.svh"

module job_fetch_broker_selector_core
   import jfbs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [2:0]               req_op,
   input  wire logic [BIDX_W-1:0]        req_broker_index,
   input  wire logic signed [PRIO_W-1:0] req_top_priority,
   input  wire logic [QUEUE_W-1:0]       req_queue_len,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [2:0]                    rsp_action,
   output logic [BIDX_W-1:0]             rsp_target_broker,
   output logic [1:0]                    rsp_fetch_state,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [TICK_W-1:0]        csr_data
);

   ctl_type           ctl_ff, ctl_in;
   fetch_type         fsm_ff, fsm_in;
   logic [BIDX_W-1:0] chosen_ff, chosen_in;
   logic              chosen_valid_ff, chosen_valid_in;
   logic [TICK_W-1:0] countdown_ff, countdown_in;
   logic [TICK_W-1:0] timeout_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   action_type        rsp_action_ff, rsp_action_in;
   logic [BIDX_W-1:0] rsp_target_ff, rsp_target_in;
   fetch_type         rsp_state_ff, rsp_state_in;

   logic              accept;
   logic              out_free;
   logic              in_range;
   logic              scan_start;
   logic              out_load;
   tbl_wr_type        tbl_wr;
   tbl_clr_type       tbl_clr;
   tbl_rd_type        tbl_rd;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   scan_stat_type     scan_stat;
   op_type            op;

   assign op       = op_type'(req_op);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign in_range = (CNT_W'(req_broker_index) < CNT_W'(NUM_BROKERS));

   jfbs_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .clr     (tbl_clr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (tbl_rd)
   );

   jfbs_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .rd_data (tbl_rd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .stat    (scan_stat)
   );

   // Timeout register written by a configuration transfer.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= RETRY_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_data;
      end
   end

   // Sequencer next state.
   always_comb begin
      ctl_in = ctl_ff;
      unique case (ctl_ff)
         CTL_READY: begin
            if (scan_start) begin
               ctl_in = CTL_SCAN;
            end
         end
         CTL_SCAN: begin
            if (scan_stat.done && out_free) begin
               ctl_in = CTL_READY;
            end
         end
         default: ctl_in = CTL_READY;
      endcase
   end

   // Event handling, table updates and result selection.
   always_comb begin
      fsm_in          = fsm_ff;
      chosen_in       = chosen_ff;
      chosen_valid_in = chosen_valid_ff;
      countdown_in    = countdown_ff;
      rsp_action_in   = ACT_NONE;
      rsp_target_in   = '0;
      rsp_state_in    = fsm_ff;
      scan_start      = 1'b0;
      out_load        = 1'b0;
      tbl_wr.en       = 1'b0;
      tbl_wr.addr     = ADDR_W'(req_broker_index);
      tbl_wr.prio     = req_top_priority;
      tbl_wr.queue    = req_queue_len;
      tbl_clr.en      = 1'b0;
      tbl_clr.addr    = ADDR_W'(req_broker_index);
      req_stall       = (ctl_ff != CTL_READY) || !out_free;

      unique case (ctl_ff)
         CTL_READY: begin
            if (accept) begin
               out_load = 1'b1;
               unique case (op)
                  OP_ANNOUNCE: begin
                     tbl_wr.en  = in_range;
                     scan_start = (fsm_ff == FETCH_WAIT);
                  end
                  OP_REPLY_JOB: begin
                     rsp_target_in = req_broker_index;
                     if (fsm_ff == FETCH_TRY && chosen_valid_ff &&
                         chosen_ff == req_broker_index) begin
                        rsp_action_in = ACT_DELIVER;
                        fsm_in        = FETCH_PROC;
                     end else begin
                        rsp_action_in = ACT_IGNORED;
                     end
                  end
                  OP_REPLY_NO: begin
                     tbl_clr.en = in_range;
                     scan_start = (fsm_ff == FETCH_TRY);
                  end
                  OP_REQUEST: begin
                     scan_start = (fsm_ff == FETCH_IDLE);
                  end
                  OP_DONE: begin
                     if (fsm_ff == FETCH_PROC && chosen_valid_ff) begin
                        rsp_action_in   = ACT_RESULT;
                        rsp_target_in   = chosen_ff;
                        chosen_valid_in = 1'b0;
                        fsm_in          = FETCH_IDLE;
                     end
                  end
                  OP_TICK: begin
                     if (fsm_ff == FETCH_TRY) begin
                        if (countdown_ff <= TICK_W'(1)) begin
                           // Timed out: drop the chosen broker and try again.
                           tbl_clr.en   = chosen_valid_ff;
                           tbl_clr.addr = ADDR_W'(chosen_ff);
                           scan_start   = 1'b1;
                        end else begin
                           countdown_in = countdown_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               // A selecting event reports only at the end of its scan.
               if (scan_start) begin
                  out_load = 1'b0;
               end
               rsp_state_in = fsm_in;
            end
         end
         CTL_SCAN: begin
            if (scan_stat.done && out_free) begin
               out_load = 1'b1;
               if (scan_stat.found) begin
                  chosen_in       = BIDX_W'(scan_stat.best);
                  chosen_valid_in = 1'b1;
                  fsm_in          = FETCH_TRY;
                  countdown_in    = timeout_ff;
                  rsp_action_in   = ACT_GET_JOB;
                  rsp_target_in   = BIDX_W'(scan_stat.best);
               end else begin
                  chosen_valid_in = 1'b0;
                  fsm_in          = FETCH_WAIT;
               end
               rsp_state_in = fsm_in;
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff          <= CTL_READY;
         fsm_ff          <= FETCH_IDLE;
         chosen_ff       <= '0;
         chosen_valid_ff <= 1'b0;
         countdown_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         ctl_ff          <= ctl_in;
         fsm_ff          <= fsm_in;
         chosen_ff       <= chosen_in;
         chosen_valid_ff <= chosen_valid_in;
         countdown_ff    <= countdown_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_action_ff <= rsp_action_in;
         rsp_target_ff <= rsp_target_in;
         rsp_state_ff  <= rsp_state_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_action_ff;
   assign rsp_target_broker = rsp_target_ff;
   assign rsp_fetch_state   = rsp_state_ff;

   // A broker is chosen exactly while the fetcher is trying or processing.
   `JFBS_ASSERT(a_chosen_state, clock, reset, chosen_valid_ff == ((fsm_ff == FETCH_TRY) || (fsm_ff == FETCH_PROC)))
   // A get-job result always reports the trying state.
   `JFBS_ASSERT_IMPL(a_get_job_try, clock, reset, rsp_valid_ff && (rsp_action_ff == ACT_GET_JOB), rsp_state_ff == FETCH_TRY)
   // No event is taken while a scan is in progress.
   `JFBS_ASSERT_IMPL(a_scan_stall, clock, reset, ctl_ff == CTL_SCAN, req_stall)

endmodule

`default_nettype wire
